// File: hdl/rmt_pkg.sv
package rmt_pkg;

  localparam int CAP_W = 31;
  localparam int IDX_W = 8;
  localparam int ST_W  = 2;
  localparam int FN_W  = 2;

  localparam int MAX_SEGMENTS_DEFAULT = 256;

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

  // operation codes
  localparam logic [FN_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FN_W-1:0] FN_UPDATE = 2'd1;
  localparam logic [FN_W-1:0] FN_QUERY  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_CAP   = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

endpackage

// File: hdl/rmt_ram.sv
module rmt_ram
  import rmt_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT,
  localparam int ADDR_W = $clog2(MAX_SEGMENTS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CAP_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [CAP_W-1:0]  rd_data
);

  logic [CAP_W-1:0] mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/range_minimum_table.sv
// Range-minimum store with point update.
// Input channel (in_valid/in_ready) carries one operation per beat: func
// selects append, update at position, or minimum query over
// position..range_end. Output channel (out_valid/out_ready) returns one
// result beat per input beat, in order: status, min_capacity (zero unless
// a query succeeds) and segment_count after the operation.
// Append and update write the capacity memory in the accept cycle; their
// result goes into the result registers and moves on to the output register
// once it is free. A query walks the range, up to MAX_SEGMENTS entries, one
// memory read per cycle through the single read port of the capacity
// memory, and its result then takes the same path to the output register.
// Failed operations change nothing.
// One operation is in flight at a time; the next beat is taken as soon as
// the current result sits in the output register, even if the receiver
// stalls. A stalled result holds until taken.
// Reset empties the store (used_count zero); memory contents are not
// cleared since only written entries are ever read.
module range_minimum_table
  import rmt_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT,
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [FN_W-1:0]  func,
  input  logic [IDX_W-1:0] position,
  input  logic [IDX_W-1:0] range_end,
  input  logic [CAP_W-1:0] capacity,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  status,
  output logic [CAP_W-1:0] min_capacity,
  output logic [CNT_W-1:0] segment_count
);

  localparam int ADDR_W = $clog2(MAX_SEGMENTS);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t            state;
  logic [CNT_W-1:0]  used_count;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] last_q;
  logic              issue_done;
  logic              pend;
  logic              pend_last;
  logic [CAP_W-1:0]  best;
  logic [ST_W-1:0]   res_status;
  logic [CAP_W-1:0]  res_min;
  logic [CNT_W-1:0]  res_count;

  logic              accept;
  logic [ST_W-1:0]   chk_status;
  logic [CMP_W-1:0]  used_c;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  last_c;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CAP_W-1:0]  rd_data;
  logic [CAP_W-1:0]  walk_min;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign used_c = CMP_W'(used_count);
  assign pos_c  = CMP_W'(position);
  assign last_c = CMP_W'(range_end);

  always_comb begin
    chk_status = ST_OK;
    unique case (func)
      FN_APPEND: begin
        if (capacity == '0) chk_status = ST_BAD_CAP;
        else if (used_count == CNT_W'(MAX_SEGMENTS)) chk_status = ST_FULL;
      end
      FN_UPDATE: begin
        if (pos_c >= used_c) chk_status = ST_BAD_INDEX;
        else if (capacity == '0) chk_status = ST_BAD_CAP;
      end
      FN_QUERY: begin
        if (position > range_end || last_c >= used_c) chk_status = ST_BAD_INDEX;
      end
      default: chk_status = ST_OK;
    endcase
  end

  assign wr_en   = accept && (chk_status == ST_OK) &&
                   (func == FN_APPEND || func == FN_UPDATE);
  assign wr_addr = (func == FN_APPEND) ? used_count[ADDR_W-1:0] : pos_c[ADDR_W-1:0];

  rmt_ram #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(capacity),
    .rd_addr(addr),
    .rd_data(rd_data)
  );

  assign walk_min = (rd_data < best) ? rd_data : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      out_valid  <= 1'b0;
      issue_done <= 1'b0;
      pend       <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == FN_QUERY && chk_status == ST_OK) begin
              addr       <= pos_c[ADDR_W-1:0];
              last_q     <= last_c[ADDR_W-1:0];
              issue_done <= 1'b0;
              pend       <= 1'b0;
              pend_last  <= 1'b0;
              best       <= CAP_MAX;
              res_status <= ST_OK;
              res_count  <= used_count;
              state      <= S_WALK;
            end else begin
              res_status <= chk_status;
              res_min    <= '0;
              if (func == FN_APPEND && chk_status == ST_OK) begin
                used_count <= used_count + 1'b1;
                res_count  <= used_count + 1'b1;
              end else begin
                res_count  <= used_count;
              end
              state <= S_DONE;
            end
          end
        end
        S_WALK: begin
          // reads issue one per cycle; data lands in the following cycle
          pend      <= !issue_done;
          pend_last <= (addr == last_q);
          if (!issue_done) begin
            if (addr == last_q) issue_done <= 1'b1;
            else addr <= addr + 1'b1;
          end
          if (pend) begin
            best <= walk_min;
            if (pend_last) begin
              res_min <= walk_min;
              state   <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status        <= res_status;
            min_capacity  <= res_min;
            segment_count <= res_count;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/range_minimum_table_test.sv
`timescale 1ns / 100ps

module range_minimum_table_test;
  import rmt_pkg::*;

  localparam int SEG_MAX = MAX_SEGMENTS_DEFAULT;
  localparam int CNT_W = $clog2(SEG_MAX + 1);
  localparam int RANDOM_OPS = 1600;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [FN_W-1:0] FN_UNUSED = 2'd3;

  typedef struct {
    logic [FN_W-1:0]  fn;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] last;
    logic [CAP_W-1:0] cap;
    bit               drain;
  } table_op_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CAP_W-1:0] min_cap;
    logic [CNT_W-1:0] count;
  } table_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [FN_W-1:0]  func = '0;
  logic [IDX_W-1:0] position = '0;
  logic [IDX_W-1:0] range_end = '0;
  logic [CAP_W-1:0] capacity = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ST_W-1:0]  status;
  logic [CAP_W-1:0] min_capacity;
  logic [CNT_W-1:0] segment_count;

  range_minimum_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .position      (position),
    .range_end     (range_end),
    .capacity      (capacity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .min_capacity  (min_capacity),
    .segment_count (segment_count)
  );

  always #5 clk = ~clk;

  table_op_t        pending_ops[$];
  table_result_t    predicted_results[$];
  logic [CAP_W-1:0] model_caps [SEG_MAX];
  logic [CNT_W-1:0] model_count = '0;
  int               plan_count = 0;
  int               sent_ops = 0;
  int               phase_len = 0;
  int               hold_at = 0;
  int               mismatches = 0;
  bit               tx_fire = 1'b0;
  bit               rx_hold = 1'b0;

  // Applies one operation to the shadow table and returns the result beat.
  function automatic table_result_t predict_table_op(input logic [FN_W-1:0] fn,
                                                     input logic [IDX_W-1:0] pos,
                                                     input logic [IDX_W-1:0] last,
                                                     input logic [CAP_W-1:0] cap);
    table_result_t    r;
    logic [CAP_W-1:0] best;
    r = '{status: ST_OK, min_cap: '0, count: '0};
    case (fn)
      FN_APPEND: begin
        if (cap == '0) r.status = ST_BAD_CAP;
        else if (model_count >= SEG_MAX) r.status = ST_FULL;
        else begin
          model_caps[model_count[IDX_W-1:0]] = cap;
          model_count++;
        end
      end
      FN_UPDATE: begin
        if (pos >= model_count) r.status = ST_BAD_INDEX;
        else if (cap == '0) r.status = ST_BAD_CAP;
        else model_caps[pos] = cap;
      end
      FN_QUERY: begin
        if (pos > last || last >= model_count) r.status = ST_BAD_INDEX;
        else begin
          best = CAP_MAX;
          for (int k = pos; k <= last; k++)
            if (model_caps[IDX_W'(k)] < best) best = model_caps[IDX_W'(k)];
          r.min_cap = best;
        end
      end
      default: ;
    endcase
    r.count = model_count;
    return r;
  endfunction

  // Queues an operation and tracks how full the store will be when it lands.
  function automatic void queue_op(input logic [FN_W-1:0] fn, input logic [IDX_W-1:0] pos,
                                   input logic [IDX_W-1:0] last,
                                   input logic [CAP_W-1:0] cap, input bit drain = 1'b0);
    table_op_t op;
    op = '{fn: fn, pos: pos, last: last, cap: cap, drain: drain};
    pending_ops.push_back(op);
    if (fn == FN_APPEND && cap != '0 && plan_count < SEG_MAX) plan_count++;
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    logic [CAP_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = CAP_MAX;
      1, 2, 3: c = CAP_W'($urandom_range(1, 100));
      default: c = CAP_W'($urandom);
    endcase
    return (c == '0) ? CAP_W'(1) : c;
  endfunction

  function automatic void queue_random_op();
    int r;
    int lo;
    int hi;
    int append_w;
    r = $urandom_range(0, 99);
    append_w = (plan_count < SEG_MAX) ? 40 : 4;
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: queue_op(FN_APPEND, IDX_W'($urandom), IDX_W'($urandom), '0);
        1: begin
          if (plan_count < SEG_MAX)
            queue_op(FN_UPDATE, IDX_W'($urandom_range(plan_count, SEG_MAX - 1)),
                     IDX_W'($urandom), pick_capacity());
          else
            queue_op(FN_UPDATE, IDX_W'($urandom), IDX_W'($urandom), '0);
        end
        2: begin
          if (plan_count < SEG_MAX && $urandom_range(0, 1) == 1) begin
            hi = $urandom_range(plan_count, SEG_MAX - 1);
            lo = $urandom_range(0, hi);
          end else begin
            lo = $urandom_range(1, SEG_MAX - 1);
            hi = $urandom_range(0, lo - 1);
          end
          queue_op(FN_QUERY, IDX_W'(lo), IDX_W'(hi), CAP_W'($urandom));
        end
        default: queue_op(FN_UNUSED, IDX_W'($urandom), IDX_W'($urandom), CAP_W'($urandom));
      endcase
    end else if (r < 8 + append_w || plan_count == 0) begin
      queue_op(FN_APPEND, IDX_W'($urandom), IDX_W'($urandom), pick_capacity());
    end else if (r < 28 + append_w) begin
      queue_op(FN_UPDATE, IDX_W'($urandom_range(0, plan_count - 1)), IDX_W'($urandom),
               pick_capacity());
    end else begin
      // mostly short ranges keep the walk cheap; a few span the whole store
      lo = $urandom_range(0, plan_count - 1);
      case ($urandom_range(0, 49))
        0: begin
          lo = 0;
          hi = plan_count - 1;
        end
        1, 2: hi = $urandom_range(lo, plan_count - 1);
        default: begin
          hi = lo + $urandom_range(0, 7);
          if (hi >= plan_count) hi = plan_count - 1;
        end
      endcase
      queue_op(FN_QUERY, IDX_W'(lo), IDX_W'(hi), CAP_W'($urandom));
    end
  endfunction

  // driver: one beat offered at a time, held until taken
  always @(negedge clk) begin
    table_op_t op;
    int        tx_pct;
    int        rx_pct;
    if (sent_ops < phase_len) begin
      tx_pct = 20;
      rx_pct = 74;
    end else if (sent_ops < 2 * phase_len) begin
      tx_pct = 74;
      rx_pct = 20;
    end else begin
      tx_pct = 0;
      rx_pct = 0;
    end
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_pct);
      if (!in_valid || tx_fire) begin
        if (pending_ops.size() == 0 ||
            (pending_ops[0].drain && predicted_results.size() != 0) ||
            $urandom_range(0, 99) < tx_pct) begin
          in_valid <= 1'b0;
        end else begin
          op = pending_ops.pop_front();
          func <= op.fn;
          position <= op.pos;
          range_end <= op.last;
          capacity <= op.cap;
          in_valid <= 1'b1;
          sent_ops++;
        end
      end
    end
  end

  // monitor: predicts on each input beat, checks each output beat
  always @(posedge clk) begin
    table_result_t want;
    tx_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready)
        predicted_results.push_back(predict_table_op(func, position, range_end, capacity));
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result beat status=%0d min=%0d count=%0d",
                     $realtime, status, min_capacity, segment_count);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (status !== want.status || min_capacity !== want.min_cap ||
              segment_count !== want.count) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp status=%0d min=%0d count=%0d, got %0d %0d %0d",
                       $realtime, want.status, want.min_cap, want.count,
                       status, min_capacity, segment_count);
            mismatches++;
          end
        end
      end
    end
  end

  // long receiver stall so the block backs up onto its input
  initial begin
    wait (hold_at > 0 && sent_ops >= hold_at);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("** range_minimum_table: FAILED **");
    $finish;
  end

  initial begin
    // empty store: every access to a position fails
    queue_op(FN_QUERY, 0, 0, 1);
    queue_op(FN_UPDATE, 0, 0, 5);
    queue_op(FN_APPEND, 0, 0, '0);
    queue_op(FN_APPEND, 0, 0, CAP_MAX);
    queue_op(FN_APPEND, 0, 0, 1);
    queue_op(FN_APPEND, 0, 0, 31'h5555_5555);
    queue_op(FN_APPEND, 0, 0, 31'h2AAA_AAAA);
    queue_op(FN_QUERY, 0, 3, '0);
    queue_op(FN_QUERY, 3, 0, '0);
    queue_op(FN_QUERY, 0, 4, '0);
    queue_op(FN_UPDATE, 4, 0, 7);
    queue_op(FN_UPDATE, 1, 0, '0);
    // bad index wins over zero capacity
    queue_op(FN_UPDATE, 8'hFF, 0, '0);
    queue_op(FN_UPDATE, 1, 0, CAP_MAX);
    queue_op(FN_QUERY, 0, 3, '0);
    queue_op(FN_QUERY, 2, 2, '0);
    queue_op(FN_QUERY, 1, 3, CAP_MAX);
    queue_op(FN_UNUSED, IDX_W'($urandom), IDX_W'($urandom), CAP_W'($urandom));
    queue_op(FN_UNUSED, 8'hFF, 8'hFF, CAP_MAX);
    queue_op(FN_APPEND, 8'hFF, 8'hFF, CAP_MAX, 1'b1);
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 2) queue_op(FN_QUERY, 0, IDX_W'(plan_count - 1), '0, 1'b1);
      else queue_random_op();
    end
    phase_len = pending_ops.size() / 3;
    hold_at = phase_len / 2;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && !in_valid && predicted_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0)
      $display("** range_minimum_table: PASSED **");
    else
      $display("** range_minimum_table: FAILED **");
    $finish;
  end

endmodule
